FILE: src/pff_pkg.sv
// Package for the power-of-two coefficient FIR filter.
// Holds sizes, action codes and the accumulator control struct; no dependencies.
package pff_pkg;

  localparam int NUM_GROUPS    = 16;
  localparam int TERM_DEPTH    = 512;
  localparam int HISTORY_DEPTH = 256;

  localparam int GROUP_AW     = $clog2(NUM_GROUPS);
  localparam int TERM_AW      = $clog2(TERM_DEPTH);
  localparam int HIST_AW      = $clog2(HISTORY_DEPTH);
  localparam int SAMPLE_W     = 16;
  localparam int ACC_W        = 40;
  localparam int SAMPLE_SHIFT = 16;
  localparam int COUNT_W      = 8;
  localparam int ADDR_W       = 9;
  localparam int WORD_W       = 9;
  localparam int DELAY_W      = 8;

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_GROUP  = 2'd1,
    ACT_TERM   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef struct packed {
    logic clear;
    logic add_en;
    logic sub;
    logic shift;
  } acc_ctrl_t;

endpackage

FILE: src/pff_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; used for the term table and the sample history.
module pff_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/pff_acc.sv
// Shared 40-bit accumulator: clear, add or subtract a scaled sample, shift right by one.
// Depends on pff_pkg.
module pff_acc (
  input  logic                                clk,
  input  pff_pkg::acc_ctrl_t                  ctrl,
  input  logic signed [pff_pkg::SAMPLE_W-1:0] operand,
  output logic signed [pff_pkg::ACC_W-1:0]    acc
);
  import pff_pkg::*;

  logic signed [ACC_W-1:0] scaled;

  // sign-extend and place the sample 16 bits up
  assign scaled = {{(ACC_W - SAMPLE_W - SAMPLE_SHIFT){operand[SAMPLE_W-1]}},
                   operand, {SAMPLE_SHIFT{1'b0}}};

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.add_en) begin
      acc <= ctrl.sub ? (acc - scaled) : (acc + scaled);
    end else if (ctrl.shift) begin
      acc <= acc >>> 1;
    end
  end

endmodule

FILE: src/pot_fir_filter.sv
// Top level of the power-of-two coefficient FIR filter.
// Depends on pff_pkg, pff_ram and pff_acc.
//
// Input channel (item_valid / item_ready): action, table_address, table_word,
// sample. Action 1 loads a group term count, action 2 a term entry (sign in
// bit 8, delay in bits 7..0), action 0 filters a sample; drop action 3 and
// out-of-range table addresses. Load transfers give no result.
// A sample walks the 16 groups in order, one term per cycle through a
// three-step pipeline (term read, history read, accumulate) around one shared
// 40-bit add/subtract/shift unit. Each group adds a count fetch, a pipeline
// drain and an arithmetic right shift; a group with no terms has no drain.
// The term read port sets the pace. No new item is taken while a sample is
// in progress. Output channel (result_valid / result_ready) carries
// filtered from an output register; the next item is taken while a result
// still waits. If the receiver stalls, hold a finished sample in the done
// state until the output register frees up. Reset empties the output
// register, zeroes the write pointer and marks the history unwritten, so
// early delays read zero with no clearing pass; the count and term tables
// must be loaded before use.
module pot_fir_filter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  logic [1:0]                          action,
  input  logic [pff_pkg::ADDR_W-1:0]          table_address,
  input  logic [pff_pkg::WORD_W-1:0]          table_word,
  input  logic signed [pff_pkg::SAMPLE_W-1:0] sample,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic signed [pff_pkg::ACC_W-1:0]    filtered
);
  import pff_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_GROUP = 4'b0010,
    S_TERM  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                  state;
  logic [GROUP_AW-1:0]     group;
  logic [TERM_AW-1:0]      slot;
  logic [COUNT_W-1:0]      issue_left;
  logic [COUNT_W-1:0]      group_counts [NUM_GROUPS];
  logic [HIST_AW-1:0]      wp;
  logic                    wrapped;
  logic                    s1_v;
  logic                    s2_v;
  logic                    s2_sign;
  logic                    s2_ok;

  logic                    accept;
  logic                    take_sample;
  logic                    load_group;
  logic                    load_term;
  logic                    term_rd_en;
  logic                    group_done;
  logic                    out_free;
  logic [WORD_W-1:0]       term_q;
  logic [HIST_AW-1:0]      hist_pos;
  logic                    hist_ok;
  logic [SAMPLE_W-1:0]     hist_q;
  logic signed [SAMPLE_W-1:0] operand;
  logic signed [ACC_W-1:0] acc;
  acc_ctrl_t               acc_ctrl;

  assign item_ready  = (state == S_IDLE);
  assign accept      = item_valid && item_ready;
  assign take_sample = accept && (action == ACT_SAMPLE);
  assign load_group  = accept && (action == ACT_GROUP) &&
                       (table_address < ADDR_W'(NUM_GROUPS));
  assign load_term   = accept && (action == ACT_TERM) &&
                       ({1'b0, table_address} < (ADDR_W + 1)'(TERM_DEPTH));

  // issue one term read per cycle while the group has terms left
  assign term_rd_en  = (state == S_TERM) && (issue_left != '0);
  // group finishes once all issued terms have drained through the pipeline
  assign group_done  = (state == S_TERM) && (issue_left == '0) && !s1_v && !s2_v;
  assign out_free    = !result_valid || result_ready;

  // history slot of the delayed sample; slots never written read as zero
  assign hist_pos = wp - term_q[DELAY_W-1:0];
  assign hist_ok  = wrapped || (hist_pos <= wp);

  assign operand = s2_ok ? hist_q : '0;

  always_comb begin
    acc_ctrl        = '0;
    acc_ctrl.clear  = take_sample;
    acc_ctrl.add_en = s2_v;
    acc_ctrl.sub    = s2_sign;
    acc_ctrl.shift  = group_done;
  end

  pff_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TERM_DEPTH)
  ) u_term_ram (
    .clk     (clk),
    .wr_en   (load_term),
    .wr_addr (table_address[TERM_AW-1:0]),
    .wr_data (table_word),
    .rd_en   (term_rd_en),
    .rd_addr (slot),
    .rd_data (term_q)
  );

  pff_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist_ram (
    .clk     (clk),
    .wr_en   (take_sample),
    .wr_addr (wp),
    .wr_data (sample),
    .rd_en   (s1_v),
    .rd_addr (hist_pos),
    .rd_data (hist_q)
  );

  pff_acc u_acc (
    .clk     (clk),
    .ctrl    (acc_ctrl),
    .operand (operand),
    .acc     (acc)
  );

  // group count table: small, read at one address, kept in flops
  always_ff @(posedge clk) begin
    if (load_group) begin
      group_counts[table_address[GROUP_AW-1:0]] <= table_word[COUNT_W-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      group        <= '0;
      slot         <= '0;
      issue_left   <= '0;
      wp           <= '0;
      wrapped      <= 1'b0;
      s1_v         <= 1'b0;
      s2_v         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_v <= term_rd_en;
      s2_v <= s1_v;
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take_sample) begin
            group <= '0;
            slot  <= '0;
            state <= S_GROUP;
          end
        end
        S_GROUP: begin
          issue_left <= group_counts[group];
          state      <= S_TERM;
        end
        S_TERM: begin
          if (term_rd_en) begin
            issue_left <= issue_left - 1'b1;
            // advance the term slot, wrapping at the table depth
            slot <= (slot == TERM_AW'(TERM_DEPTH - 1)) ? '0 : slot + 1'b1;
          end
          if (group_done) begin
            if (group == GROUP_AW'(NUM_GROUPS - 1)) begin
              state <= S_DONE;
            end else begin
              group <= group + 1'b1;
              state <= S_GROUP;
            end
          end
        end
        S_DONE: begin
          // hold the finished sample until the output register frees up
          if (out_free) begin
            result_valid <= 1'b1;
            wp           <= wp + 1'b1;
            if (wp == HIST_AW'(HISTORY_DEPTH - 1)) begin
              wrapped <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (s1_v) begin
      s2_sign <= term_q[WORD_W-1];
      s2_ok   <= hist_ok;
    end
    if (state == S_DONE && out_free) begin
      filtered <= acc;
    end
  end

  a_s1_follows_issue: assert property (@(posedge clk) disable iff (rst)
    s1_v |-> $past(term_rd_en))
    else $error("term pipeline stage valid without a term read");

  a_s2_follows_s1: assert property (@(posedge clk) disable iff (rst)
    s2_v |-> $past(s1_v))
    else $error("history stage valid without a term stage");

  a_shift_alone: assert property (@(posedge clk) disable iff (rst)
    acc_ctrl.shift |-> !acc_ctrl.add_en && !acc_ctrl.clear)
    else $error("group shift collides with an accumulate");

  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && $past(state) == S_TERM) |->
      $past(group) == GROUP_AW'(NUM_GROUPS - 1))
    else $error("sample finished before the last group");

  a_busy_no_ready: assert property (@(posedge clk) disable iff (rst)
    (s1_v || s2_v) |-> (state == S_TERM) && !item_ready)
    else $error("term pipeline active outside the term walk");

endmodule
